[rtl/rtpl_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtpl_pkg: shared types and constants of the route table lookup core
// Beat payloads, table entry layout, function and status codes, and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package rtpl_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W       = 6;   // mask length 0..32
   localparam int ATTR_W      = 5;

   // Function codes
   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;
   localparam logic [1:0] STATUS_NO_ROUTE  = 2'd3;

   // Attribute layout: bit 0 up, bit 1 via gateway, bits 4..2 interface
   localparam logic [ATTR_W-1:0] ATTR_UP      = 5'h01;
   localparam logic [ATTR_W-1:0] ATTR_GW      = 5'h02;
   localparam int                ATTR_UP_BIT  = 0;
   localparam int                ATTR_GW_BIT  = 1;
   localparam int                ATTR_PORT_LO = 2;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] dest_addr;
      logic [31:0] net_mask;
      logic [31:0] gateway_addr;
      logic        flag_up;
      logic        flag_via_gateway;
      logic [2:0]  port_sel;
      logic [3:0]  entry_index;
   } rtpl_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_hop;
      logic [3:0]  out_port;
   } rtpl_rsp_type;

   typedef struct packed {
      logic [31:0]       dest;
      logic [31:0]       mask;
      logic [31:0]       gateway;
      logic [ATTR_W-1:0] attrs;
   } rtpl_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic append_wr;
      logic walk_init;
      logic walk_step;
      logic finish;
   } rtpl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       table_full;
      logic       index_bad;
      logic       walk_done;
   } rtpl_stat_type;

endpackage

[rtl/route_table_prefix_lookup_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// route_table_prefix_lookup_core: IPv4 static route table with LPM lookup
// Append, delete and longest-prefix lookup over an ordered route table.
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; one result beat comes
// back on rsp_data, marked by rsp_strobe for exactly one cycle, and the
// receiver cannot stall it. Beats are handled one at a time. busy falls in
// the strobe cycle, so the next beat may be taken then. A delete or lookup
// walks the table, which reads one entry per cycle through the single read
// port of the route memory and shifts or compares it the cycle after.
// ---------------------------------------------------------------------------
module route_table_prefix_lookup_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rtpl_pkg::rtpl_req_type req_data,
   output logic                   rsp_strobe,
   output rtpl_pkg::rtpl_rsp_type rsp_data
);
   import rtpl_pkg::*;

   rtpl_cmd_type  cmd;
   rtpl_stat_type stat;

   rtpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   rtpl_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/rtpl_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtpl_datapath: route table storage and walk datapath
// Holds the route memory and entry count, walks entries one per cycle for
// delete (shift down) and lookup (longest prefix), and builds the result.
// ---------------------------------------------------------------------------
module rtpl_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rtpl_pkg::rtpl_cmd_type cmd,
   input  rtpl_pkg::rtpl_req_type req_data,
   output rtpl_pkg::rtpl_stat_type stat,
   output rtpl_pkg::rtpl_rsp_type rsp_data
);
   import rtpl_pkg::*;

   // Route memory, no reset: only entries below the count are read
   rtpl_entry_type mem [TABLE_DEPTH];

   rtpl_req_type      req_ff,       req_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic [CNT_W-1:0]  ptr_ff,       ptr_in;
   logic [CNT_W-1:0]  rd_ptr_ff,    rd_ptr_in;
   logic              rd_valid_ff,  rd_valid_in;
   rtpl_entry_type    rd_entry_ff;
   logic              full_ff,      full_in;
   logic              bad_ff,       bad_in;
   logic              found_ff,     found_in;
   logic [LEN_W-1:0]  best_len_ff,  best_len_in;
   logic [31:0]       best_gw_ff,   best_gw_in;
   logic [ATTR_W-1:0] best_attr_ff, best_attr_in;
   rtpl_rsp_type      rsp_ff,       rsp_in;

   logic              is_lookup;
   logic              is_delete;
   logic              issue;
   logic              hit;
   logic              better;
   logic [LEN_W-1:0]  cand_len;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   rtpl_entry_type    wr_entry;
   rtpl_entry_type    new_entry;

   assign is_lookup = (req_ff.func == FUNC_LOOKUP);
   assign is_delete = (req_ff.func == FUNC_DELETE);
   assign issue     = cmd.walk_step && (ptr_ff < count_ff);

   // Candidate check on the entry read last cycle
   assign hit      = rd_entry_ff.attrs[ATTR_UP_BIT] &&
                     ((req_ff.dest_addr & rd_entry_ff.mask) == rd_entry_ff.dest);
   assign cand_len = LEN_W'($countones(rd_entry_ff.mask));
   assign better   = hit && (!found_ff || (cand_len > best_len_ff));

   // Entry built from the captured append beat
   always_comb begin
      new_entry.dest    = req_ff.dest_addr;
      new_entry.mask    = req_ff.net_mask;
      new_entry.gateway = req_ff.gateway_addr;
      new_entry.attrs   = ATTR_W'({req_ff.port_sel, 2'b00})
                        | (req_ff.flag_up          ? ATTR_UP : '0)
                        | (req_ff.flag_via_gateway ? ATTR_GW : '0);
   end

   // Single write port: append at the tail, or shift down during delete
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = count_ff[IDX_W-1:0];
      wr_entry = new_entry;
      if (cmd.append_wr) begin
         wr_en = 1'b1;
      end else if (cmd.walk_step && rd_valid_ff && is_delete) begin
         wr_en    = 1'b1;
         wr_addr  = IDX_W'(rd_ptr_ff - CNT_W'(1));
         wr_entry = rd_entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (issue) begin
         rd_entry_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   // Next-state logic
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_valid_in  = rd_valid_ff;
      full_in      = full_ff;
      bad_in       = bad_ff;
      found_in     = found_ff;
      best_len_in  = best_len_ff;
      best_gw_in   = best_gw_ff;
      best_attr_in = best_attr_ff;
      rsp_in       = rsp_ff;

      if (cmd.capture) begin
         req_in = req_data;
      end

      if (cmd.decode) begin
         full_in = stat.table_full;
         bad_in  = stat.index_bad;
      end

      if (cmd.append_wr) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.walk_init) begin
         ptr_in      = is_delete ? (CNT_W'(req_ff.entry_index) + CNT_W'(1)) : '0;
         rd_valid_in = 1'b0;
         found_in    = 1'b0;
         best_len_in = '0;
      end

      // One entry read and one entry evaluated per step
      if (cmd.walk_step) begin
         rd_valid_in = issue;
         if (issue) begin
            ptr_in    = ptr_ff + CNT_W'(1);
            rd_ptr_in = ptr_ff;
         end
         if (rd_valid_ff && is_lookup && better) begin
            found_in     = 1'b1;
            best_len_in  = cand_len;
            best_gw_in   = rd_entry_ff.gateway;
            best_attr_in = rd_entry_ff.attrs;
         end
      end

      // Result beat and delete count update
      if (cmd.finish) begin
         rsp_in = '0;
         unique case (req_ff.func)
            FUNC_APPEND: begin
               rsp_in.status = full_ff ? STATUS_FULL : STATUS_OK;
            end
            FUNC_DELETE: begin
               rsp_in.status = bad_ff ? STATUS_BAD_INDEX : STATUS_OK;
               if (!bad_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FUNC_LOOKUP: begin
               if (found_ff) begin
                  rsp_in.status   = STATUS_OK;
                  rsp_in.next_hop = best_attr_ff[ATTR_GW_BIT] ? best_gw_ff
                                                              : req_ff.dest_addr;
                  rsp_in.out_port = 4'({1'b0, best_attr_ff[ATTR_W-1:ATTR_PORT_LO]})
                                  + 4'd1;
               end else begin
                  rsp_in.status = STATUS_NO_ROUTE;
               end
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      ptr_ff       <= ptr_in;
      rd_ptr_ff    <= rd_ptr_in;
      full_ff      <= full_in;
      bad_ff       <= bad_in;
      best_len_ff  <= best_len_in;
      best_gw_ff   <= best_gw_in;
      best_attr_ff <= best_attr_in;
      rsp_ff       <= rsp_in;
   end

   // Status to controller
   assign stat.func       = req_ff.func;
   assign stat.table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.index_bad  = (CNT_W'(req_ff.entry_index) >= count_ff);
   assign stat.walk_done  = (ptr_ff >= count_ff) && !rd_valid_ff;

   assign rsp_data = rsp_ff;

   // Count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // Every read in flight points at a valid entry
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (rd_ptr_ff < count_ff))
      else $error("table read beyond entry count");

   // Append never lands on a full table
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append_wr |-> !stat.table_full)
      else $error("append issued on full table");

endmodule

[rtl/rtpl_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtpl_ctrl: route table lookup controller
// Sequences capture, decode, table walk and result for one beat at a time.
// ---------------------------------------------------------------------------
module rtpl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  rtpl_pkg::rtpl_stat_type stat,
   output rtpl_pkg::rtpl_cmd_type  cmd
);
   import rtpl_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_WALK   = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;

   logic [1:0] state_ff,  state_in;
   logic       strobe_ff, strobe_in;

   // State transitions and commands
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode    = 1'b1;
            cmd.walk_init = 1'b1;
            if ((stat.func == FUNC_APPEND) && !stat.table_full) begin
               cmd.append_wr = 1'b1;
            end
            if ((stat.func == FUNC_LOOKUP) ||
                ((stat.func == FUNC_DELETE) && !stat.index_bad)) begin
               state_in = S_WALK;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.finish = 1'b1;
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   // Accepted beat always goes through decode
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECODE))
      else $error("accepted beat did not reach decode");

   // Result strobe follows the result state, and only it
   a_strobe_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_RESP))
      else $error("result strobe without result state");

   // Strobe lasts one cycle per beat
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held more than one cycle");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for route_table_prefix_lookup_core
// Drives append, delete and lookup beats through the start/busy handshake,
// keeps a shadow route table that predicts every result beat, and compares
// each strobed result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
   import rtpl_pkg::*;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         STALL_LIMIT   = 5000;  // cycles with no beat moving
   localparam int         TAIL_CYCLES   = 32;    // outlasts the longest walk
   localparam int         REPORT_LIMIT  = 10;
   localparam int         REQ_BITS      = $bits(rtpl_req_type);

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   rtpl_req_type req_data;
   logic         rsp_strobe;
   rtpl_rsp_type rsp_data;

   // Shadow route table
   rtpl_entry_type rt_entry [TABLE_DEPTH];
   int             rt_count;

   rtpl_rsp_type   route_expect_q[$];
   int             fail_count;
   int             stall_cycles;
   int             sender_idle_pct;

   route_table_prefix_lookup_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #6 clock = ~clock;

   // Prefix mask with len ones from the top
   function automatic logic [31:0] mask_of_len(input int len);
      return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
   endfunction

   // Next-hop prediction; updates the shadow table for appends and deletes
   function automatic rtpl_rsp_type predict_route_beat(input rtpl_req_type beat);
      rtpl_rsp_type res;
      int best;
      int best_len;
      int len;
      res = '0;
      res.status = STATUS_OK;
      case (beat.func)
         FUNC_APPEND: begin
            if (rt_count >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               rt_entry[rt_count].dest    = beat.dest_addr;
               rt_entry[rt_count].mask    = beat.net_mask;
               rt_entry[rt_count].gateway = beat.gateway_addr;
               rt_entry[rt_count].attrs   = {beat.port_sel, beat.flag_via_gateway,
                                             beat.flag_up};
               rt_count++;
            end
         end
         FUNC_DELETE: begin
            if (int'(beat.entry_index) >= rt_count) begin
               res.status = STATUS_BAD_INDEX;
            end else begin
               for (int i = beat.entry_index; i < rt_count - 1; i++)
                  rt_entry[i] = rt_entry[i + 1];
               rt_count--;
            end
         end
         FUNC_LOOKUP: begin
            best = -1;
            best_len = 0;
            for (int i = 0; i < rt_count; i++) begin
               if (rt_entry[i].attrs[ATTR_UP_BIT] &&
                   ((beat.dest_addr & rt_entry[i].mask) == rt_entry[i].dest)) begin
                  len = $countones(rt_entry[i].mask);
                  // strict compare keeps the earlier route on a tie
                  if (best < 0 || len > best_len) begin
                     best = i;
                     best_len = len;
                  end
               end
            end
            if (best >= 0) begin
               res.next_hop = rt_entry[best].attrs[ATTR_GW_BIT] ?
                              rt_entry[best].gateway : beat.dest_addr;
               res.out_port = {1'b0, rt_entry[best].attrs[ATTR_PORT_LO +: 3]} + 4'd1;
            end else begin
               res.status = STATUS_NO_ROUTE;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic note_failure(input string what, input logic [31:0] exp,
                               input logic [31:0] act);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t ns: %s mismatch: expected %h, got %h", $realtime, what, exp, act);
   endtask

   // Result checker and prediction at accept
   always @(posedge clock) begin
      rtpl_rsp_type exp;
      if (!reset) begin
         if (rsp_strobe) begin
            if (route_expect_q.size() == 0) begin
               note_failure("unexpected result beat", 32'h0, {30'h0, rsp_data.status});
            end else begin
               exp = route_expect_q.pop_front();
               if (rsp_data.status !== exp.status)
                  note_failure("status", {30'h0, exp.status}, {30'h0, rsp_data.status});
               if (rsp_data.next_hop !== exp.next_hop)
                  note_failure("next_hop", exp.next_hop, rsp_data.next_hop);
               if (rsp_data.out_port !== exp.out_port)
                  note_failure("out_port", {28'h0, exp.out_port}, {28'h0, rsp_data.out_port});
            end
         end
         if (start && !busy)
            route_expect_q.push_back(predict_route_beat(req_data));
      end
   end

   // Watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Send one beat; returns at the falling edge after it was taken
   task automatic send_route_beat(input rtpl_req_type beat);
      int gap;
      gap = 0;
      while (gap < 400 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding result is back
   task automatic pause_until_drained();
      start <= 1'b0;
      while (route_expect_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic rtpl_req_type make_route(input logic [31:0] dest,
         input logic [31:0] mask, input logic [31:0] gw, input logic up,
         input logic via, input logic [2:0] port);
      rtpl_req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
      r.func             = FUNC_APPEND;
      r.dest_addr        = dest;
      r.net_mask         = mask;
      r.gateway_addr     = gw;
      r.flag_up          = up;
      r.flag_via_gateway = via;
      r.port_sel         = port;
      return r;
   endfunction

   function automatic rtpl_req_type make_lookup(input logic [31:0] addr);
      rtpl_req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
      r.func      = FUNC_LOOKUP;
      r.dest_addr = addr;
      return r;
   endfunction

   function automatic rtpl_req_type make_delete(input logic [3:0] idx);
      rtpl_req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
      r.func        = FUNC_DELETE;
      r.entry_index = idx;
      return r;
   endfunction

   // Random route: nested prefixes around known destinations, some noise
   function automatic rtpl_req_type draw_route();
      rtpl_req_type r;
      logic [31:0]  base;
      logic [31:0]  mask;
      int           pick;
      int           sel;
      r = make_route($urandom, $urandom, $urandom, $urandom_range(99) < 85,
                     1'($urandom_range(1)), 3'($urandom_range(7)));
      sel = $urandom_range(99);
      if (sel < 10) begin
         // noise: raw mask and destination as drawn
      end else if (sel < 20 && rt_count > 0) begin
         // same prefix as an existing route, so lookups can tie
         pick = $urandom_range(rt_count - 1);
         r.dest_addr = rt_entry[pick].dest;
         r.net_mask  = rt_entry[pick].mask;
      end else begin
         base = $urandom;
         if (rt_count > 0 && $urandom_range(1))
            base = rt_entry[$urandom_range(rt_count - 1)].dest;
         mask = ($urandom_range(2) == 0) ? mask_of_len($urandom_range(8, 24))
                                         : mask_of_len($urandom_range(32));
         r.dest_addr = base & mask;
         r.net_mask  = mask;
      end
      return r;
   endfunction

   // Random beat, weighted by how full the table is
   function automatic rtpl_req_type draw_route_beat();
      rtpl_req_type r;
      int           append_pct;
      int           sel;
      int           pick;
      append_pct = (rt_count < 3) ? 60 : (rt_count == TABLE_DEPTH) ? 15 : 30;
      sel = $urandom_range(99);
      if (sel < 2) begin
         r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
         r.func = FUNC_UNUSED;
      end else if (sel < 2 + append_pct) begin
         r = draw_route();
      end else if (sel < 17 + append_pct) begin
         if (rt_count > 0 && $urandom_range(99) < 85)
            r = make_delete(4'($urandom_range(rt_count - 1)));
         else
            r = make_delete(4'($urandom_range(15)));
      end else begin
         if (rt_count > 0 && $urandom_range(99) < 75) begin
            pick = $urandom_range(rt_count - 1);
            r = make_lookup((rt_entry[pick].dest & rt_entry[pick].mask) |
                            ($urandom & ~rt_entry[pick].mask));
         end else begin
            r = make_lookup($urandom);
         end
      end
      return r;
   endfunction

   // Special cases on a small hand-built table
   task automatic test_directed_cases();
      sender_idle_pct = 0;
      send_route_beat(make_lookup(32'h0A00_0001));      // empty table
      send_route_beat(make_delete(4'd0));               // bad index on empty
      send_route_beat({FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b1, 1'b1, 3'd7, 4'd15});
      send_route_beat(make_route(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7));
      send_route_beat(make_route(32'h0A00_0000, 32'hFF00_0000, 32'h0, 1'b1, 1'b0, 3'd0));
      send_route_beat(make_route(32'h0A01_0000, 32'hFFFF_0000, 32'h0, 1'b0, 1'b0, 3'd3));
      send_route_beat(make_route(32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001,
                                 1'b1, 1'b1, 3'd2));
      send_route_beat(make_route(32'h0A01_0000, 32'hFFFF_0000, 32'h0, 1'b1, 1'b0, 3'd5));
      send_route_beat(make_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 3'd4));
      // non-contiguous mask
      send_route_beat(make_route(32'h1100_2200, 32'hFF00_FF00, 32'h0BAD_F00D,
                                 1'b1, 1'b1, 3'd6));
      // destination outside its own mask never matches
      send_route_beat(make_route(32'hC0A8_0101, 32'hFFFF_0000, 32'h0, 1'b1, 1'b0, 3'd1));
      send_route_beat(make_lookup(32'h0A01_0203));      // /16 tie, earlier wins
      send_route_beat(make_lookup(32'h0A02_0304));
      send_route_beat(make_lookup(32'hFFFF_FFFF));
      send_route_beat(make_lookup(32'h11AA_22BB));
      send_route_beat(make_lookup(32'hC0A8_0101));
      send_route_beat(make_delete(4'd0));
      send_route_beat(make_lookup(32'h1234_5678));      // no default left
      send_route_beat(make_delete(4'd2));
      send_route_beat(make_lookup(32'h0A01_0203));
      send_route_beat(make_delete(4'd6));               // index equals count
      send_route_beat(make_delete(4'd5));
      pause_until_drained();
   endtask

   // Fill to capacity, overflow, then trim both ends
   task automatic test_table_full();
      while (rt_count < TABLE_DEPTH)
         send_route_beat(draw_route());
      send_route_beat(draw_route());
      send_route_beat(make_lookup($urandom));
      send_route_beat(make_delete(4'd15));
      send_route_beat(make_delete(4'd0));
      send_route_beat(draw_route());
      pause_until_drained();
   endtask

   task automatic run_random_phase(input int n_beats, input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int n = 0; n < n_beats; n++) begin
         send_route_beat(draw_route_beat());
         if ($urandom_range(63) == 0)
            pause_until_drained();
      end
      pause_until_drained();
   endtask

   task automatic test_random_back_to_back();
      run_random_phase(510, 0);
   endtask

   task automatic test_random_sparse_sender();
      run_random_phase(510, 88);
   endtask

   task automatic test_random_light_gaps();
      run_random_phase(510, 7);
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      rt_count        = 0;
      fail_count      = 0;
      stall_cycles    = 0;
      sender_idle_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_table_full();
      test_random_back_to_back();
      test_random_sparse_sender();
      test_random_light_gaps();

      // tail: catch stray strobes after the last result
      pause_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (route_expect_q.size() != 0) begin
         fail_count++;
         $display("%0d results never arrived", route_expect_q.size());
      end
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
